FILE: sv/mccs_pkg.sv
package mccs_pkg;

    localparam int ENTRY_W = 48;
    localparam int IN_W    = 112;
    localparam int OUT_W   = 128;
    localparam int CNT_MAX = 127;

    typedef logic [ENTRY_W-1:0] move_entry_t;

    localparam logic [2:0] CMD_MOVE  = 3'd0;
    localparam logic [2:0] CMD_DONE  = 3'd1;
    localparam logic [2:0] CMD_TICK  = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_CHAIN = 3'd4;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_CHAIN  = 3'd2;
    localparam logic [2:0] ACT_REPORT = 3'd3;
    localparam logic [2:0] ACT_STOP   = 3'd4;

    localparam logic CFG_ENCODER = 1'b0;
    localparam logic CFG_DEFER   = 1'b1;

    localparam logic [15:0] DEFER_RESET = 16'd50;

endpackage

FILE: sv/motion_command_chain_sequencer_unit.sv
// Stepper move sequencer. Each command is a one-beat transfer on the s_ side (command in s_tuser)
// and yields exactly one result transfer on the m_ side (action in m_tuser). In the idle state
// the accept reads the move ring at the read pointer (synchronous memory), and in the exec
// state the block decides, updates the ring and pointers and loads the output register.
// A new command is taken while a result still waits; its exec state holds until the output
// register is free. Up to QUEUE_DEPTH-1 moves wait in the ring, further requests are dropped
// and flagged. There is no clearing pass after reset. Write cfg_* only while idle.
module motion_command_chain_sequencer_unit #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_addr,
    input  logic [15:0]                cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [2:0]                 s_tuser,   // command
    // direction, step_period, step_count, steps_remaining, current_coord
    input  logic [mccs_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [2:0]                 m_tuser,   // action
    // move_direction, move_period, move_steps, target_coord, target_valid, moving,
    // report_coord, dropped, queued_count, zero fill
    output logic [mccs_pkg::OUT_W-1:0] m_tdata
);

    localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    mccs_pkg::move_entry_t ring_mem [QUEUE_DEPTH];
    mccs_pkg::move_entry_t rd_data_reg;

    logic                      state_reg, state_next;
    logic [2:0]                cmd_reg;
    logic [mccs_pkg::IN_W-1:0] in_reg;
    logic [PTR_W-1:0]          rp_reg, rp_next, wp_reg, wp_next;
    logic                      stream_reg, stream_next;
    logic                      armed_reg, armed_next;
    logic [15:0]               ticks_reg, ticks_next;
    logic                      motion_reg, motion_next;
    logic                      enc_reg;
    logic [15:0]               defer_reg;

    logic                      m_tvalid_reg;
    logic [2:0]                m_tuser_reg;
    logic [mccs_pkg::OUT_W-1:0] m_tdata_reg;

    logic                      commit;
    logic                      empty, full, push, dropped;
    logic                      issue_en;
    logic [2:0]                act;
    mccs_pkg::move_entry_t     issue_entry;
    logic [31:0]               remaining, coord, target, report;
    logic [30:0]               stp;
    logic [15:0]               tk;
    logic [CNT_W-1:0]          cnt_wide;
    logic [6:0]                queued;
    logic [PTR_W-1:0]          wp_inc, rp_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;
    assign commit    = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign remaining = in_reg[79:48];
    assign coord     = in_reg[111:80];
    assign empty     = (rp_reg == wp_reg);
    assign wp_inc    = (wp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc    = (rp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign full      = (wp_inc == rp_reg);
    assign state_next = (state_reg == ST_IDLE) ? (s_tvalid ? ST_EXEC : ST_IDLE)
                                               : (commit ? ST_IDLE : ST_EXEC);

    always_comb
    begin
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        stream_next = stream_reg;
        armed_next  = armed_reg;
        ticks_next  = ticks_reg;
        motion_next = motion_reg;
        push        = 1'b0;
        dropped     = 1'b0;
        issue_en    = 1'b0;
        act         = mccs_pkg::ACT_NONE;
        issue_entry = in_reg[47:0];
        report      = '0;
        tk          = (ticks_reg != 16'hFFFF) ? ticks_reg + 16'd1 : ticks_reg;
        unique case (cmd_reg)
            mccs_pkg::CMD_MOVE:
            begin
                armed_next = 1'b0;
                if (remaining != '0 || !empty)
                begin
                    if (full)
                        dropped = 1'b1;
                    else
                    begin
                        push    = 1'b1;
                        wp_next = wp_inc;
                    end
                end
                else
                begin
                    issue_en    = 1'b1;
                    act         = stream_reg ? mccs_pkg::ACT_CHAIN : mccs_pkg::ACT_START;
                    stream_next = 1'b1;
                end
            end
            mccs_pkg::CMD_DONE:
            begin
                if (!empty)
                begin
                    rp_next     = rp_inc;
                    armed_next  = 1'b0;
                    stream_next = 1'b1;
                    issue_en    = 1'b1;
                    issue_entry = rd_data_reg;
                    act         = mccs_pkg::ACT_CHAIN;
                end
                else if (stream_reg)
                begin
                    armed_next = 1'b1;
                    ticks_next = '0;
                end
                else
                    act = mccs_pkg::ACT_REPORT;
            end
            mccs_pkg::CMD_TICK:
            begin
                if (armed_reg)
                begin
                    ticks_next = tk;
                    if (remaining == '0 && empty && tk >= defer_reg)
                        act = mccs_pkg::ACT_REPORT;
                end
            end
            mccs_pkg::CMD_STOP:
            begin
                rp_next    = '0;
                wp_next    = '0;
                ticks_next = '0;
                act        = mccs_pkg::ACT_STOP;
            end
            mccs_pkg::CMD_CHAIN:
            begin
                if (!empty)
                begin
                    rp_next     = rp_inc;
                    issue_en    = 1'b1;
                    issue_entry = rd_data_reg;
                    act         = mccs_pkg::ACT_CHAIN;
                end
            end
            default:
            begin
                act = mccs_pkg::ACT_NONE;
            end
        endcase
        if (issue_en)
            motion_next = 1'b1;
        if (act == mccs_pkg::ACT_REPORT || act == mccs_pkg::ACT_STOP)
        begin
            armed_next  = 1'b0;
            stream_next = 1'b0;
            motion_next = 1'b0;
            report      = coord;
        end
    end

    assign stp    = issue_entry[47:17];
    assign target = issue_entry[0] ? coord - {1'b0, stp} : coord + {1'b0, stp};
    assign cnt_wide = (wp_next >= rp_next)
                    ? CNT_W'(wp_next) - CNT_W'(rp_next)
                    : CNT_W'(wp_next) + CNT_W'(QUEUE_DEPTH) - CNT_W'(rp_next);
    assign queued = (32'(cnt_wide) > 32'(mccs_pkg::CNT_MAX)) ? 7'(mccs_pkg::CNT_MAX)
                                                              : 7'(cnt_wide);

    // ring memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (commit && push)
            ring_mem[wp_reg] <= in_reg[47:0];
        if (s_tvalid && s_tready)
            rd_data_reg <= ring_mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            in_reg  <= s_tdata;
        end
        if (commit)
        begin
            m_tuser_reg <= act;
            m_tdata_reg <= {6'd0, queued, dropped, report, motion_next,
                            issue_en & enc_reg,
                            (issue_en & enc_reg) ? target : 32'd0,
                            issue_en ? issue_entry : mccs_pkg::move_entry_t'(0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rp_reg       <= '0;
            wp_reg       <= '0;
            stream_reg   <= 1'b0;
            armed_reg    <= 1'b0;
            ticks_reg    <= '0;
            motion_reg   <= 1'b0;
            enc_reg      <= 1'b0;
            defer_reg    <= mccs_pkg::DEFER_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_addr == mccs_pkg::CFG_ENCODER)
                    enc_reg <= cfg_wdata[0];
                else
                    defer_reg <= cfg_wdata;
            end
            if (commit)
            begin
                rp_reg       <= rp_next;
                wp_reg       <= wp_next;
                stream_reg   <= stream_next;
                armed_reg    <= armed_next;
                ticks_reg    <= ticks_next;
                motion_reg   <= motion_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(rp_reg) < QUEUE_DEPTH) && (32'(wp_reg) < QUEUE_DEPTH))
        else $error("ring pointer out of range");
    a_stop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == mccs_pkg::ACT_STOP) |-> (m_tdata[121:115] == 7'd0))
        else $error("stop left moves in the ring");
    a_issue_moving: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == mccs_pkg::ACT_START || m_tuser == mccs_pkg::ACT_CHAIN))
        |-> (m_tdata[81] && !m_tdata[114]))
        else $error("issued move without motion");
    a_drop_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && dropped) |=> (m_tvalid && m_tuser == mccs_pkg::ACT_NONE))
        else $error("dropped request produced an action");
`endif

endmodule

FILE: test/testbench.sv
module testbench;

    localparam int RING_SLOTS  = 128;
    localparam int STALL_LIMIT = 3000;
    localparam int FILL_MOVES  = 135;

    // command codes the block ignores
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic [31:0] coord;
        logic [31:0] remaining;
        logic [30:0] steps;
        logic [15:0] period;
        logic        dir;
        logic [2:0]  cmd;
    } cmd_item_t;

    typedef struct packed {
        logic [6:0]  queued;
        logic        dropped;
        logic [31:0] report;
        logic        moving;
        logic        target_ok;
        logic [31:0] target;
        logic [30:0] steps;
        logic [15:0] period;
        logic        dir;
        logic [2:0]  action;
    } move_result_t;

    typedef struct packed {
        logic [30:0] steps;
        logic [15:0] period;
        logic        dir;
    } move_slot_t;

    typedef struct packed {
        cmd_item_t    item;
        logic         typed;
        move_result_t want;
    } directed_row_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic                          cfg_addr  = 1'b0;
    logic [15:0]                   cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [2:0]                    s_tuser   = '0;
    logic [mccs_pkg::IN_W-1:0]     s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [2:0]                    m_tuser;
    logic [mccs_pkg::OUT_W-1:0]    m_tdata;

    // predictor state and configuration
    move_slot_t  plan_ring [RING_SLOTS];
    logic [6:0]  plan_rd      = '0;
    logic [6:0]  plan_wr      = '0;
    logic        plan_stream  = 1'b0;
    logic        plan_armed   = 1'b0;
    logic        plan_moving  = 1'b0;
    logic [15:0] plan_ticks   = '0;
    logic        plan_encoder = 1'b0;
    logic [15:0] plan_defer   = mccs_pkg::DEFER_RESET;

    move_result_t  expected_results [$];
    directed_row_t directed_rows [19];
    int            failures      = 0;
    int            idle_cycles   = 0;
    int            src_idle_pct  = 0;
    int            sink_stall_pct = 0;

    logic        phase_encoder [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [15:0] phase_defer   [6] = '{16'd0, 16'hffff, 16'd3, 16'd1, 16'd10, 16'd2};
    int          phase_src     [6] = '{0, 70, 0, 23, 70, 0};
    int          phase_sink    [6] = '{0, 0, 70, 23, 0, 70};

    motion_command_chain_sequencer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic move_result_t launch_move(logic [2:0] act, move_slot_t m,
                                                 logic [31:0] coord);
        move_result_t r;
        r        = '0;
        r.action = act;
        r.dir    = m.dir;
        r.period = m.period;
        r.steps  = m.steps;
        if (plan_encoder)
        begin
            r.target    = m.dir ? coord - {1'b0, m.steps} : coord + {1'b0, m.steps};
            r.target_ok = 1'b1;
        end
        plan_moving = 1'b1;
        return r;
    endfunction

    function automatic move_result_t go_idle(logic [2:0] act, logic [31:0] coord);
        move_result_t r;
        r           = '0;
        plan_armed  = 1'b0;
        plan_stream = 1'b0;
        plan_moving = 1'b0;
        r.action    = act;
        r.report    = coord;
        return r;
    endfunction

    function automatic move_result_t sequencer_step(cmd_item_t it);
        move_result_t r;
        move_slot_t   m;
        logic         waiting;
        r       = '0;
        m       = '{steps: it.steps, period: it.period, dir: it.dir};
        waiting = (plan_rd != plan_wr);
        case (it.cmd)
            mccs_pkg::CMD_MOVE:
            begin
                plan_armed = 1'b0;
                if (it.remaining != 32'd0 || waiting)
                begin
                    if (7'(plan_wr + 7'd1) == plan_rd)
                        r.dropped = 1'b1;
                    else
                    begin
                        plan_ring[plan_wr] = m;
                        plan_wr            = plan_wr + 7'd1;
                    end
                end
                else
                begin
                    r           = launch_move(plan_stream ? mccs_pkg::ACT_CHAIN
                                                          : mccs_pkg::ACT_START,
                                              m, it.coord);
                    plan_stream = 1'b1;
                end
            end
            mccs_pkg::CMD_DONE:
            begin
                if (waiting)
                begin
                    plan_armed  = 1'b0;
                    plan_stream = 1'b1;
                    r           = launch_move(mccs_pkg::ACT_CHAIN, plan_ring[plan_rd],
                                              it.coord);
                    plan_rd     = plan_rd + 7'd1;
                end
                else if (plan_stream)
                begin
                    plan_armed = 1'b1;
                    plan_ticks = '0;
                end
                else
                    r = go_idle(mccs_pkg::ACT_REPORT, it.coord);
            end
            mccs_pkg::CMD_TICK:
            begin
                if (plan_armed)
                begin
                    if (plan_ticks != 16'hffff)
                        plan_ticks = plan_ticks + 16'd1;
                    if (it.remaining == 32'd0 && !waiting && plan_ticks >= plan_defer)
                        r = go_idle(mccs_pkg::ACT_REPORT, it.coord);
                end
            end
            mccs_pkg::CMD_STOP:
            begin
                plan_rd    = '0;
                plan_wr    = '0;
                plan_ticks = '0;
                r          = go_idle(mccs_pkg::ACT_STOP, it.coord);
            end
            mccs_pkg::CMD_CHAIN:
            begin
                if (waiting)
                begin
                    r       = launch_move(mccs_pkg::ACT_CHAIN, plan_ring[plan_rd], it.coord);
                    plan_rd = plan_rd + 7'd1;
                end
            end
            default:
            begin
            end
        endcase
        r.moving = plan_moving;
        r.queued = plan_wr - plan_rd;
        return r;
    endfunction

    function automatic cmd_item_t draw_command(logic filling, int idx);
        cmd_item_t it;
        int        pick;
        pick         = $urandom_range(99);
        it.dir       = 1'($urandom_range(1));
        it.period    = 16'($urandom);
        it.steps     = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(2000));
        it.coord     = $urandom;
        it.remaining = (pick < 50) ? 32'd0 :
                       (pick < 90) ? 32'($urandom_range(500, 1)) : 32'($urandom);
        if (filling)
        begin
            // long run of busy requests overflows the ring, then drain it
            if (idx < FILL_MOVES)
            begin
                it.cmd = mccs_pkg::CMD_MOVE;
                if (it.remaining == 32'd0)
                    it.remaining = 32'd1;
            end
            else
                it.cmd = (idx % 4 == 0) ? mccs_pkg::CMD_CHAIN : mccs_pkg::CMD_DONE;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 34)
                it.cmd = mccs_pkg::CMD_MOVE;
            else if (pick < 54)
                it.cmd = mccs_pkg::CMD_DONE;
            else if (pick < 78)
                it.cmd = mccs_pkg::CMD_TICK;
            else if (pick < 90)
                it.cmd = mccs_pkg::CMD_CHAIN;
            else if (pick < 96)
                it.cmd = mccs_pkg::CMD_STOP;
            else
                it.cmd = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
        end
        return it;
    endfunction

    task automatic send_command(cmd_item_t it, logic typed, move_result_t want);
        move_result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.coord, it.remaining, it.steps, it.period, it.dir};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = sequencer_step(it);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic load_registers(logic encoder, logic [15:0] defer);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= mccs_pkg::CFG_ENCODER;
        cfg_wdata <= {15'd0, encoder};
        @(posedge clk);
        cfg_addr  <= mccs_pkg::CFG_DEFER;
        cfg_wdata <= defer;
        @(posedge clk);
        cfg_we    <= 1'b0;
        plan_encoder = encoder;
        plan_defer   = defer;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            failures++;
        end
    endfunction

    // result side: random stall
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        move_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with none expected, action %0h", m_tuser);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("action", want.action, m_tuser);
                check_field("move_direction", want.dir, m_tdata[0]);
                check_field("move_period", want.period, m_tdata[16:1]);
                check_field("move_steps", want.steps, m_tdata[47:17]);
                check_field("target_coord", want.target, m_tdata[79:48]);
                check_field("target_valid", want.target_ok, m_tdata[80]);
                check_field("moving", want.moving, m_tdata[81]);
                check_field("report_coord", want.report, m_tdata[113:82]);
                check_field("dropped", want.dropped, m_tdata[114]);
                check_field("queued_count", want.queued, m_tdata[121:115]);
                check_field("zero_fill", '0, m_tdata[127:122]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int n;
        directed_rows = '{
            '{item: '{cmd: mccs_pkg::CMD_TICK, default: '0}, typed: 1'b1,
              want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_DONE, coord: 32'h8000_0000, default: '0},
              typed: 1'b1,
              want: '{action: mccs_pkg::ACT_REPORT, report: 32'h8000_0000, default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_MOVE, dir: 1'b1, period: 16'hffff,
                      steps: 31'h7fff_ffff, default: '0}, typed: 1'b1,
              want: '{action: mccs_pkg::ACT_START, dir: 1'b1, period: 16'hffff,
                      steps: 31'h7fff_ffff, moving: 1'b1, default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_MOVE, remaining: 32'hffff_ffff,
                      coord: 32'h7fff_ffff, default: '0}, typed: 1'b1,
              want: '{moving: 1'b1, queued: 7'd1, default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_MOVE, dir: 1'b1, period: 16'h1234, steps: 31'd5,
                      default: '0}, typed: 1'b0, want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_CHAIN, coord: 32'h7fff_ffff, default: '0},
              typed: 1'b0, want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_DONE, coord: 32'd100, default: '0}, typed: 1'b0,
              want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_DONE, default: '0}, typed: 1'b0,
              want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_TICK, remaining: 32'd5, default: '0}, typed: 1'b0,
              want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_CHAIN, default: '0}, typed: 1'b0,
              want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_MOVE, period: 16'd40, steps: 31'h7fff_ffff,
                      coord: 32'h7fff_ffff, default: '0}, typed: 1'b0,
              want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_STOP, coord: 32'h7fff_ffff, default: '0},
              typed: 1'b1,
              want: '{action: mccs_pkg::ACT_STOP, report: 32'h7fff_ffff, default: '0}},
            '{item: '{cmd: CMD_RSVD5, default: '1}, typed: 1'b1, want: '{default: '0}},
            '{item: '{cmd: CMD_RSVD6, default: '0}, typed: 1'b1, want: '{default: '0}},
            '{item: '{cmd: CMD_RSVD7, default: '1}, typed: 1'b1, want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_MOVE, coord: 32'h8000_0000, default: '0},
              typed: 1'b1,
              want: '{action: mccs_pkg::ACT_START, moving: 1'b1, default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_DONE, default: '0}, typed: 1'b0,
              want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_TICK, remaining: 32'hffff_ffff, default: '0},
              typed: 1'b0, want: '{default: '0}},
            '{item: '{cmd: mccs_pkg::CMD_STOP, default: '0}, typed: 1'b1,
              want: '{action: mccs_pkg::ACT_STOP, default: '0}}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_command(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        for (int p = 0; p < 6; p++)
        begin
            load_registers(phase_encoder[p], phase_defer[p]);
            src_idle_pct   = phase_src[p];
            sink_stall_pct = phase_sink[p];
            n = (p == 1) ? 2 * FILL_MOVES : 240;
            for (int i = 0; i < n; i++)
                send_command(draw_command(p == 1, i), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/mccs_pkg.sv
sv/motion_command_chain_sequencer_unit.sv
test/testbench.sv
